// ----- hdl/tfp_pkg.sv -----
// Shared constants and types for the TLB / page-table translator.
`timescale 1ns / 1ps

package tfp_pkg;

	// Fixed field widths
	localparam int ADDR_W = 16;
	localparam int CNT_W  = 32;

	// Default sizing of the top level
	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_COUNT_DEF  = 256;
	localparam int OFFSET_BITS_DEF = 8;

	// Result tuser bit positions and width
	localparam int TU_HIT   = 0;
	localparam int TU_FAULT = 1;
	localparam int TU_DIRTY = 2;
	localparam int TU_W     = 3;

	// Write commands from the lookup control to the page table
	typedef struct packed {
		logic fault_wr;  // page becomes valid, frame is stored
		logic evict_wr;  // evicted TLB entry marks its page dirty
	} pt_cmd_t;

endpackage

// ----- hdl/tfp_tlb_cell.sv -----
// One TLB entry of the shifting FIFO chain: holds tag, frame, valid and dirty.
`timescale 1ns / 1ps

module tfp_tlb_cell #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic             mark_dirty,
	input  logic [TAG_W-1:0] lookup_page,
	input  logic             in_valid,
	input  logic             in_dirty,
	input  logic [TAG_W-1:0] in_tag,
	input  logic [TAG_W-1:0] in_frame,
	output logic             valid,
	output logic             dirty,
	output logic [TAG_W-1:0] tag,
	output logic [TAG_W-1:0] frame,
	output logic             match
);

	logic             valid_q;
	logic             dirty_q;
	logic [TAG_W-1:0] tag_q;
	logic [TAG_W-1:0] frame_q;

	// Control bits: take the neighbor's entry on a shift, else set dirty on a write hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (shift) begin
			valid_q <= in_valid;
			dirty_q <= in_dirty;
		end else if (mark_dirty && match) begin
			dirty_q <= 1'b1;
		end
	end

	// Payload moves with the chain
	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q   <= in_tag;
			frame_q <= in_frame;
		end
	end

	assign match = valid_q && (tag_q == lookup_page);
	assign valid = valid_q;
	assign dirty = dirty_q;
	assign tag   = tag_q;
	assign frame = frame_q;

endmodule

// ----- hdl/tfp_page_table.sv -----
// Page table: frame, valid and dirty memories with a clearing pass after reset.
`timescale 1ns / 1ps

module tfp_page_table #(
	parameter int PAGE_COUNT = tfp_pkg::PAGE_COUNT_DEF,
	parameter int PAGE_W     = $clog2(PAGE_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [PAGE_W-1:0]   rd_page,
	input  tfp_pkg::pt_cmd_t    cmd,
	input  logic [PAGE_W-1:0]   wr_page,
	input  logic [PAGE_W-1:0]   fault_frame,
	input  logic [PAGE_W-1:0]   evict_page,
	output logic                rd_valid,
	output logic                rd_dirty,
	output logic [PAGE_W-1:0]   rd_frame,
	output logic                busy
);

	logic              valid_mem [PAGE_COUNT];
	logic              dirty_mem [PAGE_COUNT];
	logic [PAGE_W-1:0] frame_mem [PAGE_COUNT];

	logic              clr_busy_q;
	logic [PAGE_W-1:0] clr_idx_q;

	logic              rd_valid_q;
	logic              rd_dirty_q;
	logic [PAGE_W-1:0] rd_frame_q;

	// Clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == PAGE_W'(PAGE_COUNT - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// Valid memory: cleared by the sweep, set on a fault
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			valid_mem[clr_idx_q] <= 1'b0;
		else if (cmd.fault_wr)
			valid_mem[wr_page] <= 1'b1;
		if (rd_en)
			rd_valid_q <= valid_mem[rd_page];
	end

	// Dirty memory: cleared by the sweep, set by a dirty eviction
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			dirty_mem[clr_idx_q] <= 1'b0;
		else if (cmd.evict_wr)
			dirty_mem[evict_page] <= 1'b1;
		if (rd_en)
			rd_dirty_q <= dirty_mem[rd_page];
	end

	// Frame memory: written once per page on its fault, never cleared
	always_ff @(posedge clk) begin
		if (cmd.fault_wr)
			frame_mem[wr_page] <= fault_frame;
		if (rd_en)
			rd_frame_q <= frame_mem[rd_page];
	end

	assign rd_valid = rd_valid_q;
	assign rd_dirty = rd_dirty_q;
	assign rd_frame = rd_frame_q;
	assign busy     = clr_busy_q;

endmodule

// ----- hdl/tlb_fifo_page_translator.sv -----
// Top level: address translator with a FIFO-replaced TLB chain and a page table.
`timescale 1ns / 1ps

// Input channel s_*: one logical address per item, tuser carries the write flag.
// Output channel m_*: one translation per item: physical address and running
// hit / fault counts in tdata, hit, fault and dirty flags in tuser.
// On accept the page-table memories are read and the item enters the lookup
// state; the lookup step then searches the TLB cell chain, writes back the page
// table, shifts the chain on a miss and loads the output register, which drives
// m_tvalid. The page-table read-then-write-back sets the rate: the next item is
// taken only after the write-back. The output register frees s_tready for the
// next item while a result waits; a stalled m_tready holds the result and the
// next item waits in the lookup step until the output register is taken.
// After reset the page table runs a clearing pass with s_tready low; the TLB and
// the counters clear at once. PAGE_COUNT must be a power of two; the block does
// not enforce it. Page numbers wrap modulo PAGE_COUNT.
module tlb_fifo_page_translator #(
	parameter int TLB_ENTRIES = tfp_pkg::TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT  = tfp_pkg::PAGE_COUNT_DEF,
	parameter int OFFSET_BITS = tfp_pkg::OFFSET_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,   // [15:0] vaddr
	input  logic [0:0]                 s_tuser,   // [0] write_access
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [79:0]                m_tdata,   // [15:0] paddr, [47:16] hit_total,
	                                              // [79:48] fault_total
	output logic [tfp_pkg::TU_W-1:0]   m_tuser    // [0] tlb_hit, [1] page_fault, [2] page_dirty
);

	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int ADDR_W = tfp_pkg::ADDR_W;
	localparam int CNT_W  = tfp_pkg::CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	state_t state_q;

	// Accepted item
	logic [PAGE_W-1:0]      page_s1;
	logic [OFFSET_BITS-1:0] offset_s1;
	logic                   wr_s1;

	// Page table
	logic             pt_rd_valid;
	logic             pt_rd_dirty;
	logic [PAGE_W-1:0] pt_rd_frame;
	logic             pt_busy;
	tfp_pkg::pt_cmd_t pt_cmd;

	// TLB chain
	logic              cell_valid  [TLB_ENTRIES];
	logic              cell_dirty  [TLB_ENTRIES];
	logic [PAGE_W-1:0] cell_tag    [TLB_ENTRIES];
	logic [PAGE_W-1:0] cell_frame  [TLB_ENTRIES];
	logic              chain_valid [TLB_ENTRIES];
	logic              chain_dirty [TLB_ENTRIES];
	logic [PAGE_W-1:0] chain_tag   [TLB_ENTRIES];
	logic [PAGE_W-1:0] chain_frame [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] match_vec;

	// Counters and frame allocator
	logic [CNT_W-1:0]  hit_cnt_q;
	logic [CNT_W-1:0]  fault_cnt_q;
	logic [PAGE_W:0]   free_q;

	// Output register
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_phys_q;
	logic              out_hit_q;
	logic              out_fault_q;
	logic              out_dirty_q;
	logic [CNT_W-1:0]  out_hits_q;
	logic [CNT_W-1:0]  out_faults_q;

	logic              s_accept;
	logic              do_look;
	logic              hit;
	logic              fault;
	logic              tlb_insert;
	logic              tlb_mark;
	logic              hit_dirty;
	logic [PAGE_W-1:0] hit_frame;
	logic [PAGE_W-1:0] new_frame;
	logic              new_dirty;
	logic [PAGE_W-1:0] use_frame;
	logic              use_dirty;
	logic [ADDR_W-1:0] addr_shift;
	logic [PAGE_W-1:0] in_page;

	// Input split
	assign addr_shift = s_tdata[ADDR_W-1:0] >> OFFSET_BITS;
	assign in_page    = PAGE_W'(addr_shift);

	assign s_tready = (state_q == ST_IDLE) && !pt_busy;
	assign s_accept = s_tvalid && s_tready;
	assign do_look  = (state_q == ST_LOOK) && (!out_valid_q || m_tready);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (s_accept) state_q <= ST_LOOK;
				ST_LOOK: if (do_look) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (s_accept) begin
			page_s1   <= in_page;
			offset_s1 <= s_tdata[OFFSET_BITS-1:0];
			wr_s1     <= s_tuser[0];
		end
	end

	tfp_page_table #(
		.PAGE_COUNT (PAGE_COUNT),
		.PAGE_W     (PAGE_W)
	) u_pt (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (s_accept),
		.rd_page     (in_page),
		.cmd         (pt_cmd),
		.wr_page     (page_s1),
		.fault_frame (free_q[PAGE_W-1:0]),
		.evict_page  (cell_tag[TLB_ENTRIES-1]),
		.rd_valid    (pt_rd_valid),
		.rd_dirty    (pt_rd_dirty),
		.rd_frame    (pt_rd_frame),
		.busy        (pt_busy)
	);

	// Hit selection over the chain's match lines
	always_comb begin
		hit_frame = '0;
		hit_dirty = 1'b0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			hit_frame = hit_frame | (match_vec[i] ? cell_frame[i] : '0);
			hit_dirty = hit_dirty | (match_vec[i] & cell_dirty[i]);
		end
	end

	assign hit        = |match_vec;
	assign fault      = !hit && !pt_rd_valid;
	assign new_frame  = pt_rd_valid ? pt_rd_frame : free_q[PAGE_W-1:0];
	assign new_dirty  = pt_rd_dirty | wr_s1;
	assign tlb_insert = do_look && !hit;
	assign tlb_mark   = do_look && hit && wr_s1;
	assign use_frame  = hit ? hit_frame : new_frame;
	assign use_dirty  = hit ? (hit_dirty | wr_s1) : new_dirty;

	assign pt_cmd.fault_wr = tlb_insert && !pt_rd_valid;
	assign pt_cmd.evict_wr = tlb_insert && cell_valid[TLB_ENTRIES-1] &&
	                         cell_dirty[TLB_ENTRIES-1];

	// Chain inputs: new entry enters at cell 0, each cell takes its left neighbor
	always_comb begin
		chain_valid[0] = 1'b1;
		chain_dirty[0] = new_dirty;
		chain_tag[0]   = page_s1;
		chain_frame[0] = new_frame;
		for (int i = 1; i < TLB_ENTRIES; i++) begin
			chain_valid[i] = cell_valid[i-1];
			chain_dirty[i] = cell_dirty[i-1];
			chain_tag[i]   = cell_tag[i-1];
			chain_frame[i] = cell_frame[i-1];
		end
	end

	for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
		tfp_tlb_cell #(
			.TAG_W (PAGE_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift       (tlb_insert),
			.mark_dirty  (tlb_mark),
			.lookup_page (page_s1),
			.in_valid    (chain_valid[g]),
			.in_dirty    (chain_dirty[g]),
			.in_tag      (chain_tag[g]),
			.in_frame    (chain_frame[g]),
			.valid       (cell_valid[g]),
			.dirty       (cell_dirty[g]),
			.tag         (cell_tag[g]),
			.frame       (cell_frame[g]),
			.match       (match_vec[g])
		);
	end

	// Counters and next free frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			free_q      <= '0;
		end else if (do_look) begin
			if (hit)
				hit_cnt_q <= hit_cnt_q + 1'b1;
			if (fault) begin
				fault_cnt_q <= fault_cnt_q + 1'b1;
				if (free_q < (PAGE_W + 1)'(PAGE_COUNT))
					free_q <= free_q + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (do_look)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (do_look) begin
			out_phys_q   <= ADDR_W'({use_frame, offset_s1});
			out_hit_q    <= hit;
			out_fault_q  <= fault;
			out_dirty_q  <= use_dirty;
			out_hits_q   <= hit ? hit_cnt_q + 1'b1 : hit_cnt_q;
			out_faults_q <= fault ? fault_cnt_q + 1'b1 : fault_cnt_q;
		end
	end

	assign m_tvalid                  = out_valid_q;
	assign m_tdata                   = {out_faults_q, out_hits_q, out_phys_q};
	assign m_tuser[tfp_pkg::TU_HIT]   = out_hit_q;
	assign m_tuser[tfp_pkg::TU_FAULT] = out_fault_q;
	assign m_tuser[tfp_pkg::TU_DIRTY] = out_dirty_q;

	// No input taken while the page table is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pt_busy |-> !s_tready)
		else $error("item accepted during page-table clearing");

	// A page is held by at most one TLB entry
	a_unique_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> $onehot0(match_vec))
		else $error("page matched in more than one TLB entry");

	// A fault result never claims a TLB hit
	a_fault_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[tfp_pkg::TU_HIT] && m_tuser[tfp_pkg::TU_FAULT]))
		else $error("result marked both hit and fault");

	// A fault bumps the fault count by one
	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_look && fault) |=> (fault_cnt_q == $past(fault_cnt_q) + 1'b1))
		else $error("fault count did not advance on a fault");

endmodule
